// File: rtl/wrsi_pkg.sv
// Shared types, constants and width helpers for the Wilder RSI tracker.
`timescale 1ns / 1ps

package wrsi_pkg;

  localparam int PeriodDef    = 14;
  localparam int PriceBitsDef = 32;
  localparam int PricePortW   = 32;
  localparam int FracBits     = 16;
  localparam int RsiW         = 15;
  localparam int DivBits      = 4;   // quotient bits retired per divide cycle
  localparam int IdxW         = 4;

  localparam logic [RsiW-1:0] RSI_FULL = 15'd25600;
  localparam logic [RsiW-1:0] RSI_HALF = 15'd12800;

  // Width of the average registers, padded to a whole number of divide cycles.
  function automatic int calc_num_w(input int period, input int price_bits);
    int pw;
    int acc;
    pw  = (price_bits < PricePortW) ? price_bits : PricePortW;
    acc = pw + FracBits + $clog2(period);
    return ((acc + DivBits - 1) / DivBits) * DivBits;
  endfunction

  typedef struct packed {
    logic             capture;
    logic             accum;
    logic             smooth;
    logic             div_step;
    logic             ratio_init;
    logic             ratio_add;
    logic             add_bit;
    logic             ratio_sub;
    logic             ratio_done;
    logic             set_full;
    logic             out_load;
  } wrsi_cmd_t;

  typedef struct packed {
    logic rem_ge;
    logic loss_zero;
  } wrsi_status_t;

endpackage

// File: rtl/wrsi_ctrl.sv
// Sequencer for the RSI tracker: seeding, divide and ratio steps, output slot.
`timescale 1ns / 1ps

module wrsi_ctrl import wrsi_pkg::*; #(
  parameter int PERIOD  = PeriodDef,
  parameter int DIV_CYC = calc_num_w(PERIOD, PriceBitsDef) / DivBits
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic         ready_res_o,
  output wrsi_cmd_t    cmd_o,
  input  wrsi_status_t status_i
);

  localparam int SeedW = $clog2(PERIOD + 1);
  localparam int CntW  = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UPDATE = 3'd1;
  localparam logic [2:0] S_DIVIDE = 3'd2;
  localparam logic [2:0] S_RINIT  = 3'd3;
  localparam logic [2:0] S_RADD   = 3'd4;
  localparam logic [2:0] S_RSUB   = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0]       state_q, state_d;
  logic             have_last_q, have_last_d;
  logic             warmed_q, warmed_d;
  logic             smooth_q, smooth_d;
  logic [SeedW-1:0] seed_q, seed_d;
  logic [CntW-1:0]  div_cnt_q, div_cnt_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  logic             out_res_q, out_res_d;

  always_comb begin
    state_d     = state_q;
    have_last_d = have_last_q;
    warmed_d    = warmed_q;
    smooth_d    = smooth_q;
    seed_d      = seed_q;
    div_cnt_d   = div_cnt_q;
    idx_d       = idx_q;
    out_res_d   = out_res_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          have_last_d   = 1'b1;
          state_d       = have_last_q ? S_UPDATE : S_FINISH;
        end
      end
      S_UPDATE: begin
        cmd_o.accum  = 1'b1;
        cmd_o.smooth = warmed_q;
        smooth_d     = warmed_q;
        div_cnt_d    = CntW'(DIV_CYC - 1);
        if (warmed_q) begin
          state_d = S_DIVIDE;
        end else begin
          seed_d = seed_q + SeedW'(1);
          if (seed_q + SeedW'(1) == SeedW'(PERIOD)) begin
            warmed_d = 1'b1;
            state_d  = S_DIVIDE;
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        div_cnt_d      = div_cnt_q - CntW'(1);
        if (div_cnt_q == '0) begin
          state_d = smooth_q ? S_RINIT : S_FINISH;
        end
      end
      S_RINIT: begin
        if (status_i.loss_zero) begin
          cmd_o.set_full = 1'b1;
          state_d        = S_FINISH;
        end else begin
          cmd_o.ratio_init = 1'b1;
          idx_d            = IdxW'(RsiW - 1);
          state_d          = S_RADD;
        end
      end
      S_RADD: begin
        cmd_o.ratio_add = 1'b1;
        cmd_o.add_bit   = RSI_FULL[idx_q];
        state_d         = S_RSUB;
      end
      S_RSUB: begin
        if (status_i.rem_ge) begin
          cmd_o.ratio_sub = 1'b1;
        end else if (idx_q == '0) begin
          cmd_o.ratio_done = 1'b1;
          state_d          = S_FINISH;
        end else begin
          idx_d   = idx_q - IdxW'(1);
          state_d = S_RADD;
        end
      end
      S_FINISH: begin
        // hold the result until the output slot is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          out_res_d      = warmed_q;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      have_last_q <= 1'b0;
      warmed_q    <= 1'b0;
      smooth_q    <= 1'b0;
      seed_q      <= '0;
      div_cnt_q   <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_res_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      have_last_q <= have_last_d;
      warmed_q    <= warmed_d;
      smooth_q    <= smooth_d;
      seed_q      <= seed_d;
      div_cnt_q   <= div_cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      out_res_q   <= out_res_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign ready_res_o = out_res_q;

endmodule

// File: rtl/wrsi_datapath.sv
// Datapath: price change split, average update, divide by period, RSI ratio.
`timescale 1ns / 1ps

module wrsi_datapath import wrsi_pkg::*; #(
  parameter int PERIOD     = PeriodDef,
  parameter int PRICE_BITS = PriceBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [PricePortW-1:0] price_i,
  input  wrsi_cmd_t             cmd_i,
  output wrsi_status_t          status_o,
  output logic [RsiW-1:0]       rsi_value_o
);

  localparam int PW    = (PRICE_BITS < PricePortW) ? PRICE_BITS : PricePortW;
  localparam int NUM_W = calc_num_w(PERIOD, PRICE_BITS);
  localparam int RMW   = $clog2(PERIOD) + 1;   // remainder of divide by period
  localparam int RW    = NUM_W + 3;            // ratio remainder, below 3x divisor
  localparam logic [NUM_W-1:0] PerM1 = NUM_W'(PERIOD - 1);
  localparam logic [RMW-1:0]   PerR  = RMW'(PERIOD);

  logic [PW-1:0]    last_q;
  logic [NUM_W-1:0] g_q, l_q;
  logic [NUM_W-1:0] gain_q, gain_d, loss_q, loss_d;
  logic [RMW-1:0]   rem_g_q, rem_g_d, rem_l_q, rem_l_d;
  logic [NUM_W:0]   c_q;
  logic [RW-1:0]    rrem_q;
  logic [RsiW-1:0]  quo_q;
  logic [RsiW-1:0]  rsi_q;
  logic [RsiW-1:0]  out_rsi_q;
  logic [PW-1:0]    p;
  logic [NUM_W-1:0] gain_step, loss_step;
  logic [RMW-1:0]   rem_g_step, rem_l_step;

  assign p = price_i[PW-1:0];

  // Shift-and-subtract by the period, DivBits quotient bits per cycle.
  // The quotient fills the numerator register from the bottom.
  always_comb begin
    gain_step  = gain_q;
    loss_step  = loss_q;
    rem_g_step = rem_g_q;
    rem_l_step = rem_l_q;
    for (int k = 0; k < DivBits; k++) begin
      rem_g_step = {rem_g_step[RMW-2:0], gain_step[NUM_W-1]};
      gain_step  = {gain_step[NUM_W-2:0], 1'b0};
      if (rem_g_step >= PerR) begin
        rem_g_step   = rem_g_step - PerR;
        gain_step[0] = 1'b1;
      end
      rem_l_step = {rem_l_step[RMW-2:0], loss_step[NUM_W-1]};
      loss_step  = {loss_step[NUM_W-2:0], 1'b0};
      if (rem_l_step >= PerR) begin
        rem_l_step   = rem_l_step - PerR;
        loss_step[0] = 1'b1;
      end
    end
  end

  always_comb begin
    gain_d  = gain_q;
    loss_d  = loss_q;
    rem_g_d = rem_g_q;
    rem_l_d = rem_l_q;
    if (cmd_i.accum) begin
      rem_g_d = '0;
      rem_l_d = '0;
      if (cmd_i.smooth) begin
        gain_d = NUM_W'(gain_q * PerM1) + g_q;
        loss_d = NUM_W'(loss_q * PerM1) + l_q;
      end else begin
        gain_d = gain_q + g_q;
        loss_d = loss_q + l_q;
      end
    end else if (cmd_i.div_step) begin
      gain_d  = gain_step;
      loss_d  = loss_step;
      rem_g_d = rem_g_step;
      rem_l_d = rem_l_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= '0;
      g_q       <= '0;
      l_q       <= '0;
      gain_q    <= '0;
      loss_q    <= '0;
      rem_g_q   <= '0;
      rem_l_q   <= '0;
      c_q       <= '0;
      rrem_q    <= '0;
      quo_q     <= '0;
      rsi_q     <= RSI_HALF;
      out_rsi_q <= RSI_HALF;
    end else begin
      gain_q  <= gain_d;
      loss_q  <= loss_d;
      rem_g_q <= rem_g_d;
      rem_l_q <= rem_l_d;
      if (cmd_i.capture) begin
        last_q <= p;
        if (p > last_q) begin
          g_q <= NUM_W'({p - last_q, {FracBits{1'b0}}});
          l_q <= '0;
        end else begin
          g_q <= '0;
          l_q <= NUM_W'({last_q - p, {FracBits{1'b0}}});
        end
      end
      if (cmd_i.ratio_init) begin
        c_q    <= {1'b0, gain_q} + {1'b0, loss_q};
        rrem_q <= '0;
        quo_q  <= '0;
      end
      if (cmd_i.ratio_add) begin
        rrem_q <= {rrem_q[RW-2:0], 1'b0} + (cmd_i.add_bit ? RW'(gain_q) : RW'(0));
        quo_q  <= {quo_q[RsiW-2:0], 1'b0};
      end
      if (cmd_i.ratio_sub) begin
        rrem_q <= rrem_q - RW'(c_q);
        quo_q  <= quo_q + RsiW'(1);
      end
      if (cmd_i.ratio_done) begin
        rsi_q <= quo_q;
      end
      if (cmd_i.set_full) begin
        rsi_q <= RSI_FULL;
      end
      if (cmd_i.out_load) begin
        out_rsi_q <= rsi_q;
      end
    end
  end

  assign status_o.rem_ge    = (rrem_q >= RW'(c_q));
  assign status_o.loss_zero = (loss_q == '0);
  assign rsi_value_o        = out_rsi_q;

endmodule

// File: rtl/wilder_rsi_tracker_top.sv
// Top level of the Wilder RSI tracker: controller plus datapath.
`timescale 1ns / 1ps

// Usage: one unsigned price per input transfer (in_valid_i/in_ready_o,
// price_i); one result per input on the output channel (out_valid_o/
// out_ready_i, rsi_value_o in units of 1/256, ready_res_o once the first
// PERIOD changes are averaged). The first price after reset only records the
// previous price; results show 12800 (fifty) until the first smoothed step.
// One item is worked at a time; in_ready_o is high only while idle.
// Steps per item, input transfer to result registered:
//   first price            capture, then output load
//   seeding change         capture, average update, output load
//   seed-completing change as a seeding change, plus the divide of the
//                          averages by PERIOD, which runs 4 bits a cycle
//   smoothed change        as above, then the 15-step ratio divider, each
//                          bit an add step and then subtract steps until the
//                          remainder is below the divisor; no ratio when the average loss is zero.
// A result waits in the output register while the receiver stalls; the next
// input is taken meanwhile, and its result is held back until the slot frees.
// Reset (rst_ni low, asynchronous) clears all history and the output valid.

module wilder_rsi_tracker_top import wrsi_pkg::*; #(
  parameter int PERIOD     = PeriodDef,
  parameter int PRICE_BITS = PriceBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PricePortW-1:0] price_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [RsiW-1:0]       rsi_value_o,
  output logic                  ready_res_o
);

  localparam int DivCyc = calc_num_w(PERIOD, PRICE_BITS) / DivBits;

  wrsi_cmd_t    cmd;
  wrsi_status_t status;

  wrsi_ctrl #(
    .PERIOD  (PERIOD),
    .DIV_CYC (DivCyc)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ready_res_o (ready_res_o),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  wrsi_datapath #(
    .PERIOD     (PERIOD),
    .PRICE_BITS (PRICE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .price_i     (price_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .rsi_value_o (rsi_value_o)
  );

endmodule
